FILE: design/byte_rle_stream_encoder_unit_defines.svh
// ----------------------------------------------------------------------------
// Byte RLE stream encoder assertion macros
// Shared concurrent assertion forms, sampled on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef BYTE_RLE_STREAM_ENCODER_UNIT_DEFINES_SVH
`define BYTE_RLE_STREAM_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define BRLE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("brle assertion failed");

// Next-cycle implication.
`define BRLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("brle assertion failed");

`endif

FILE: design/brle_pkg.sv
// ----------------------------------------------------------------------------
// Byte RLE encoder package
// Constants and types shared by the encoder step logic and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brle_pkg;

  localparam int unsigned MaxResults = 6;
  localparam int unsigned CountW     = $clog2(MaxResults + 1);
  localparam int unsigned IndexW     = $clog2(MaxResults);

  localparam logic [7:0]  MarkBit    = 8'h80;
  localparam logic [7:0]  LitEscape  = 8'h81;
  localparam logic [7:0]  Newline    = 8'h0A;
  localparam logic [6:0]  MaxRun     = 7'd127;
  localparam logic [6:0]  MinRepeat  = 7'd3;
  localparam logic [15:0] LineMax    = 16'hFFFF;

  // Encoder state carried from one byte to the next.
  typedef struct packed {
    logic [7:0]  run_byte;
    logic [6:0]  run_length;
    logic [15:0] newline_total;
  } state_t;

  // All result beats caused by one input byte.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [CountW-1:0]          count;
    logic                       fin;
    logic [15:0]                lines;
  } burst_t;

endpackage

FILE: design/byte_rle_stream_encoder_unit.sv
// ----------------------------------------------------------------------------
// Byte RLE stream encoder
// Run-length encodes a byte stream, one raw byte per beat, with line count.
// ----------------------------------------------------------------------------
// Usage: raw bytes enter on the in_ channel, one per beat, with in_final_byte
// set on the last byte of a buffer. Compressed bytes leave on the out_ channel,
// one per beat. Both channels move a beat when valid is high and stall is low.
// Each input byte causes zero to six output beats; out_group_last marks the
// last beat of an input's group and out_buffer_end the last beat of a buffer,
// where out_line_count holds the saturating newline count of that buffer.
// The first beat of a group is offered the cycle after the input beat is
// accepted. Throughput: one input beat per cycle while each byte causes at
// most one output beat and out_stall stays low; a byte that causes more beats
// holds in_stall high while the six-entry burst register drains one beat per
// unstalled cycle; the next byte enters as the group's last beat is taken.
// Reset (synchronous, active low) closes any open run without output, clears
// the line count and drops any pending beats. When the receiver stalls, the
// current beat is held and in_stall stays high while any beat of the loaded
// group is still pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "byte_rle_stream_encoder_unit_defines.svh"

module byte_rle_stream_encoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_code_byte,
  output logic        out_group_last,
  output logic        out_buffer_end,
  output logic [15:0] out_line_count
);

  // Encoder state: open run and the buffer's newline count.
  brle_pkg::state_t st_r;
  brle_pkg::state_t st_nxt;
  brle_pkg::burst_t burst_nxt;

  // Burst register: all beats of the current group plus a read index.
  logic [brle_pkg::MaxResults-1:0][7:0] bytes_r;
  logic [brle_pkg::CountW-1:0]          cnt_r;
  logic [brle_pkg::IndexW-1:0]          idx_r;
  logic                                 fin_r;
  logic [15:0]                          lines_r;
  logic                                 out_valid_r;

  logic in_accept;
  logic out_take;
  logic last_beat;
  logic burst_free;

  brle_step u_step (
    .st         (st_r),
    .data_byte  (in_data_byte),
    .final_byte (in_final_byte),
    .st_nxt     (st_nxt),
    .burst      (burst_nxt)
  );

  // The last beat of a group is offered when the index reaches count - 1.
  assign last_beat  = (brle_pkg::CountW'(idx_r) + brle_pkg::CountW'(1)) == cnt_r;
  assign out_take   = out_valid_r && !out_stall;
  // A new byte may enter when nothing is pending or the last beat leaves now.
  assign burst_free = !out_valid_r || (out_take && last_beat);
  assign in_accept  = in_valid && burst_free;
  assign in_stall   = !burst_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      idx_r       <= '0;
    end else begin
      if (in_accept) begin
        st_r        <= st_nxt;
        bytes_r     <= burst_nxt.bytes;
        cnt_r       <= burst_nxt.count;
        fin_r       <= burst_nxt.fin;
        lines_r     <= burst_nxt.lines;
        idx_r       <= '0;
        out_valid_r <= (burst_nxt.count != '0);
      end else if (out_take) begin
        if (last_beat) begin
          out_valid_r <= 1'b0;
        end else begin
          idx_r <= idx_r + brle_pkg::IndexW'(1);
        end
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_byte  = bytes_r[idx_r];
  assign out_group_last = last_beat;
  assign out_buffer_end = last_beat && fin_r;
  assign out_line_count = lines_r;

  // A byte only enters while no beat but the departing last one is pending.
  `BRLE_ASSERT_NOW(a_accept_free, in_valid && !in_stall && out_valid,
                   !out_stall && out_group_last)
  // The read index always stays inside the loaded group.
  `BRLE_ASSERT_NOW(a_index_range, out_valid_r,
                   brle_pkg::CountW'(idx_r) < cnt_r)
  // A buffer's final byte always produces at least one beat.
  `BRLE_ASSERT_NEXT(a_final_emits, in_valid && !in_stall && in_final_byte,
                    out_valid)

endmodule

FILE: design/brle_step.sv
// ----------------------------------------------------------------------------
// Byte RLE encoder step
// Combinational next state and output burst for one accepted input byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brle_step (
  input  brle_pkg::state_t st,
  input  logic [7:0]       data_byte,
  input  logic             final_byte,
  output brle_pkg::state_t st_nxt,
  output brle_pkg::burst_t burst
);

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
  } seg_t;

  // Encoding of a closed run: a marker pair for long runs, literals otherwise.
  function automatic seg_t close_seg(input logic [7:0] b, input logic [6:0] len);
    seg_t s;
    s = '0;
    if (len >= brle_pkg::MinRepeat) begin
      s.bytes[0] = brle_pkg::MarkBit | {1'b0, len};
      s.bytes[1] = b;
      s.count    = 3'd2;
    end else if (len == 7'd1) begin
      if (b[7]) begin
        s.bytes[0] = brle_pkg::LitEscape;
        s.bytes[1] = b;
        s.count    = 3'd2;
      end else begin
        s.bytes[0] = b;
        s.count    = 3'd1;
      end
    end else if (len == 7'd2) begin
      if (b[7]) begin
        s.bytes[0] = brle_pkg::LitEscape;
        s.bytes[1] = b;
        s.bytes[2] = brle_pkg::LitEscape;
        s.bytes[3] = b;
        s.count    = 3'd4;
      end else begin
        s.bytes[0] = b;
        s.bytes[1] = b;
        s.count    = 3'd2;
      end
    end
    return s;
  endfunction

  logic       extend;
  logic [6:0] new_len;
  logic       close_new;
  seg_t       seg_a;
  seg_t       seg_b;
  logic [2:0] b_pos;

  assign extend    = (st.run_length != 7'd0) && (data_byte == st.run_byte) &&
                     (st.run_length != brle_pkg::MaxRun);
  assign new_len   = extend ? (st.run_length + 7'd1) : 7'd1;
  assign close_new = (new_len == brle_pkg::MaxRun) || final_byte;

  always_comb begin
    seg_a = extend ? '0 : close_seg(st.run_byte, st.run_length);
    seg_b = close_new ? close_seg(data_byte, new_len) : '0;
  end

  // Concatenate the closed old run and the closed new run, then advance the
  // open run and the newline count.
  always_comb begin
    burst.bytes = '0;
    b_pos       = '0;
    for (int k = 0; k < brle_pkg::MaxResults; k++) begin
      b_pos = 3'(k) - seg_a.count;
      if (3'(k) < seg_a.count) begin
        burst.bytes[k] = seg_a.bytes[k[1:0]];
      end else if (b_pos < seg_b.count) begin
        burst.bytes[k] = seg_b.bytes[b_pos[1:0]];
      end
    end
    burst.count = brle_pkg::CountW'(seg_a.count) + brle_pkg::CountW'(seg_b.count);

    st_nxt.run_byte      = data_byte;
    st_nxt.run_length    = close_new ? 7'd0 : new_len;
    st_nxt.newline_total = st.newline_total;
    if ((data_byte == brle_pkg::Newline) && (st.newline_total != brle_pkg::LineMax)) begin
      st_nxt.newline_total = st.newline_total + 16'd1;
    end
    burst.lines = st_nxt.newline_total;
    burst.fin   = final_byte;
    if (final_byte) begin
      st_nxt.newline_total = '0;
    end
  end

endmodule
